>>> hw/rtl/sppi_pkg.sv
// ----------------------------------------------------------------------------
// sppi_pkg: shared types and constants
// word formats, internal widths and helper functions for the segment versus
// plane-patch intersection pipeline
// ----------------------------------------------------------------------------
package sppi_pkg;

	// coordinate width, signed fixed point; the binary point does not matter
	localparam int CoordBits = 16;
	localparam int DiffBits  = CoordBits + 1;     // point differences
	localparam int CrossBits = 2 * DiffBits + 1;  // cross product components
	localparam int ProdBits  = CrossBits + DiffBits;
	localparam int SumBits   = ProdBits + 2;      // dot products, denominator
	localparam int NumBits   = SumBits + DiffBits; // dividend t * |s0|
	localparam int WideBits  = CoordBits + 3;     // point before saturation

	typedef logic [3*CoordBits-1:0]       point_t;
	typedef logic signed [CoordBits-1:0]  coord_t;
	typedef logic signed [DiffBits-1:0]   diff_t;
	typedef logic signed [CrossBits-1:0]  cross_t;
	typedef logic signed [ProdBits-1:0]   prod_t;
	typedef logic signed [SumBits-1:0]    sum_t;
	typedef logic signed [WideBits-1:0]   wcoord_t;

	typedef diff_t  dvec_t [3];
	typedef cross_t xvec_t [3];

	localparam wcoord_t SatHi = wcoord_t'((1 << (CoordBits - 1)) - 1);
	localparam wcoord_t SatLo = wcoord_t'(-(1 << (CoordBits - 1)));

	typedef struct packed {
		point_t line_start;
		point_t line_end;
		point_t edge_one_start;
		point_t edge_one_end;
		point_t edge_two_start;
		point_t edge_two_end;
	} query_t;

	typedef struct packed {
		logic   hit;
		coord_t hit_x;
		coord_t hit_y;
		coord_t hit_z;
	} result_t;

	// geometry front end to bound tests
	typedef struct packed {
		logic [2:0][CoordBits-1:0] p0;
		logic [2:0][DiffBits-1:0]  s0;
		sum_t                      d;
		sum_t                      tn;
		sum_t                      un;
		sum_t                      vn;
	} geom_t;

	// one divider step, all three axes side by side
	typedef struct packed {
		logic                      hit;
		logic [SumBits-1:0]        d;
		logic [2:0][CoordBits-1:0] p0;
		logic [2:0]                neg;
		logic [2:0][NumBits-1:0]   rem;
		logic [2:0][DiffBits-1:0]  quo;
	} div_t;

	function automatic coord_t coord_of(point_t p, int k);
		return coord_t'(p[k*CoordBits +: CoordBits]);
	endfunction

	function automatic xvec_t cross3(dvec_t a, dvec_t b);
		logic signed [2*DiffBits-1:0] m0, m1, m2, m3, m4, m5;
		xvec_t r;
		m0 = a[1] * b[2];
		m1 = a[2] * b[1];
		m2 = a[2] * b[0];
		m3 = a[0] * b[2];
		m4 = a[0] * b[1];
		m5 = a[1] * b[0];
		r[0] = CrossBits'(m0) - CrossBits'(m1);
		r[1] = CrossBits'(m2) - CrossBits'(m3);
		r[2] = CrossBits'(m4) - CrossBits'(m5);
		return r;
	endfunction

endpackage

>>> hw/rtl/sppi_geom.sv
// ----------------------------------------------------------------------------
// sppi_geom: geometry front end
// edge vectors, cross products, dot product terms and sums over four stages
// ----------------------------------------------------------------------------
module sppi_geom
	import sppi_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	output logic   up_ready,
	input  query_t up_word,
	output logic   dn_valid,
	input  logic   dn_ready,
	output geom_t  dn_word
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	coord_t p0_s1 [3], p0_s2 [3], p0_s3 [3], p0_s4 [3];
	diff_t  s0_s1 [3], s0_s2 [3], s0_s3 [3], s0_s4 [3];
	diff_t  s1_s1 [3], s2_s1 [3], w_s1 [3], w_s2 [3];
	cross_t c3_s2 [3], c4_s2 [3], c5_s2 [3];
	prod_t  td_s3 [3], tt_s3 [3], tu_s3 [3], tv_s3 [3];
	sum_t   d_s4, tn_s4, un_s4, vn_s4;

	xvec_t c3_n, c4_n, c5_n;

	assign rdy_s4   = !v_s4 || dn_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: unpack and difference
	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			for (int k = 0; k < 3; k++) begin
				p0_s1[k] <= coord_of(up_word.line_start, k);
				s0_s1[k] <= DiffBits'(coord_of(up_word.line_end, k))
					- DiffBits'(coord_of(up_word.line_start, k));
				s1_s1[k] <= DiffBits'(coord_of(up_word.edge_one_end, k))
					- DiffBits'(coord_of(up_word.edge_one_start, k));
				s2_s1[k] <= DiffBits'(coord_of(up_word.edge_two_end, k))
					- DiffBits'(coord_of(up_word.edge_two_start, k));
				w_s1[k]  <= DiffBits'(coord_of(up_word.line_start, k))
					- DiffBits'(coord_of(up_word.edge_one_start, k));
			end
		end
	end

	// stage 2: cross products
	always_comb begin
		c3_n = cross3(s1_s1, s2_s1);
		c4_n = cross3(s0_s1, s2_s1);
		c5_n = cross3(s1_s1, s0_s1);
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			p0_s2 <= p0_s1;
			s0_s2 <= s0_s1;
			w_s2  <= w_s1;
			c3_s2 <= c3_n;
			c4_s2 <= c4_n;
			c5_s2 <= c5_n;
		end
	end

	// stage 3: dot product terms
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			p0_s3 <= p0_s2;
			s0_s3 <= s0_s2;
			for (int k = 0; k < 3; k++) begin
				td_s3[k] <= c3_s2[k] * s0_s2[k];
				tt_s3[k] <= c3_s2[k] * w_s2[k];
				tu_s3[k] <= c4_s2[k] * w_s2[k];
				tv_s3[k] <= c5_s2[k] * w_s2[k];
			end
		end
	end

	// stage 4: sums, denominator negated
	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			p0_s4 <= p0_s3;
			s0_s4 <= s0_s3;
			d_s4  <= -(SumBits'(td_s3[0]) + SumBits'(td_s3[1]) + SumBits'(td_s3[2]));
			tn_s4 <= SumBits'(tt_s3[0]) + SumBits'(tt_s3[1]) + SumBits'(tt_s3[2]);
			un_s4 <= SumBits'(tu_s3[0]) + SumBits'(tu_s3[1]) + SumBits'(tu_s3[2]);
			vn_s4 <= SumBits'(tv_s3[0]) + SumBits'(tv_s3[1]) + SumBits'(tv_s3[2]);
		end
	end

	assign dn_valid = v_s4;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dn_word.p0[k] = p0_s4[k];
			dn_word.s0[k] = s0_s4[k];
		end
		dn_word.d  = d_s4;
		dn_word.tn = tn_s4;
		dn_word.un = un_s4;
		dn_word.vn = vn_s4;
	end

endmodule

>>> hw/rtl/sppi_cond.sv
// ----------------------------------------------------------------------------
// sppi_cond: sign normalization, bound tests and dividend products
// three stages between the geometry front end and the divider
// ----------------------------------------------------------------------------
module sppi_cond
	import sppi_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  geom_t up_word,
	output logic  dn_valid,
	input  logic  dn_ready,
	output div_t  dn_word
);

	logic v_s5, v_s6, v_s7;
	logic rdy_s5, rdy_s6, rdy_s7;

	logic [2:0][CoordBits-1:0] p0_s5, p0_s6;
	logic [2:0][DiffBits-1:0]  s0_s5;
	sum_t                      d_s5, tn_s5, un_s5, vn_s5;
	logic                      hit_s6;
	logic [SumBits-1:0]        d_s6, tn_s6;
	logic [2:0][DiffBits-1:0]  mag_s6;
	logic [2:0]                neg_s6;
	div_t                      out_s7;

	logic neg_d;
	logic ok_t, ok_u, ok_v;

	assign rdy_s7   = !v_s7 || dn_ready;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign up_ready = rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= up_valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	// stage 5: make the denominator nonnegative
	assign neg_d = up_word.d[SumBits-1];

	always_ff @(posedge clk) begin
		if (rdy_s5 && up_valid) begin
			p0_s5 <= up_word.p0;
			s0_s5 <= up_word.s0;
			d_s5  <= neg_d ? -up_word.d  : up_word.d;
			tn_s5 <= neg_d ? -up_word.tn : up_word.tn;
			un_s5 <= neg_d ? -up_word.un : up_word.un;
			vn_s5 <= neg_d ? -up_word.vn : up_word.vn;
		end
	end

	// stage 6: t, u, v within [0,1]
	assign ok_t = !tn_s5[SumBits-1] && (tn_s5 <= d_s5);
	assign ok_u = !un_s5[SumBits-1] && (un_s5 <= d_s5);
	assign ok_v = !vn_s5[SumBits-1] && (vn_s5 <= d_s5);

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			p0_s6  <= p0_s5;
			hit_s6 <= (d_s5 != '0) && ok_t && ok_u && ok_v;
			d_s6   <= d_s5;
			tn_s6  <= tn_s5;
			for (int k = 0; k < 3; k++) begin
				neg_s6[k] <= s0_s5[k][DiffBits-1];
				mag_s6[k] <= s0_s5[k][DiffBits-1] ? DiffBits'(-s0_s5[k]) : s0_s5[k];
			end
		end
	end

	// stage 7: dividend tn * |s0| per axis
	always_ff @(posedge clk) begin
		if (rdy_s7 && v_s6) begin
			out_s7.hit <= hit_s6;
			out_s7.d   <= d_s6;
			out_s7.p0  <= p0_s6;
			out_s7.neg <= neg_s6;
			out_s7.quo <= '0;
			for (int k = 0; k < 3; k++) begin
				out_s7.rem[k] <= NumBits'(tn_s6) * NumBits'(mag_s6[k]);
			end
		end
	end

	assign dn_valid = v_s7;
	assign dn_word  = out_s7;

	// a negated denominator must come out nonnegative
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> !d_s5[SumBits-1])
		else $error("denominator still negative after normalization");

endmodule

>>> hw/rtl/sppi_div.sv
// ----------------------------------------------------------------------------
// sppi_div: restoring divider, one quotient bit per stage, and output stage
// rounds to nearest, applies the offset to the start point and saturates
// ----------------------------------------------------------------------------
module sppi_div
	import sppi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    up_valid,
	output logic    up_ready,
	input  div_t    up_word,
	output logic    dn_valid,
	input  logic    dn_ready,
	output result_t dn_word
);

	localparam int Steps = DiffBits;

	logic v_s [Steps+1];
	logic rdy_s [Steps+2];
	div_t dv_s [Steps+1];
	div_t step_n [Steps];

	logic    v_out_q;
	result_t out_q;

	assign v_s[0]  = up_valid;
	assign dv_s[0] = up_word;
	assign rdy_s[Steps+1] = !v_out_q || dn_ready;
	assign up_ready = rdy_s[1];

	for (genvar j = 0; j < Steps; j++) begin : g_step
		localparam int Bit = Steps - 1 - j;

		assign rdy_s[j+1] = !v_s[j+1] || rdy_s[j+2];

		always_comb begin
			logic [NumBits:0] trial;
			step_n[j] = dv_s[j];
			for (int k = 0; k < 3; k++) begin
				trial = {1'b0, dv_s[j].rem[k]}
					- {1'b0, NumBits'(dv_s[j].d) << Bit};
				if (!trial[NumBits]) begin
					step_n[j].rem[k]      = trial[NumBits-1:0];
					step_n[j].quo[k][Bit] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (rdy_s[j+1]) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s[j+1] && v_s[j]) begin
				dv_s[j+1] <= step_n[j];
			end
		end
	end

	// output stage: round, offset, saturate, zero on miss
	function automatic coord_t finish(div_t s, int k);
		logic              up;
		logic [DiffBits:0] off;
		wcoord_t           base, ofs, c;
		up   = {s.rem[k][SumBits-1:0], 1'b0} >= {1'b0, s.d};
		off  = (DiffBits+1)'(s.quo[k]) + (DiffBits+1)'(up);
		base = WideBits'(coord_t'(s.p0[k]));
		ofs  = wcoord_t'({1'b0, off});
		c    = s.neg[k] ? base - ofs : base + ofs;
		if (c > SatHi) return coord_t'(SatHi);
		if (c < SatLo) return coord_t'(SatLo);
		return coord_t'(c);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (rdy_s[Steps+1]) begin
			v_out_q <= v_s[Steps];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s[Steps+1] && v_s[Steps]) begin
			out_q.hit   <= dv_s[Steps].hit;
			out_q.hit_x <= dv_s[Steps].hit ? finish(dv_s[Steps], 0) : '0;
			out_q.hit_y <= dv_s[Steps].hit ? finish(dv_s[Steps], 1) : '0;
			out_q.hit_z <= dv_s[Steps].hit ? finish(dv_s[Steps], 2) : '0;
		end
	end

	assign dn_valid = v_out_q;
	assign dn_word  = out_q;

	// a finished hit leaves a remainder below the denominator
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s[Steps] && dv_s[Steps].hit |->
			dv_s[Steps].rem[0] < NumBits'(dv_s[Steps].d)
			&& dv_s[Steps].rem[1] < NumBits'(dv_s[Steps].d)
			&& dv_s[Steps].rem[2] < NumBits'(dv_s[Steps].d))
		else $error("divider remainder not reduced");

	// a miss carries a zero point
	assert property (@(posedge clk) disable iff (!arst_n)
		v_out_q && !out_q.hit |->
			out_q.hit_x == '0 && out_q.hit_y == '0 && out_q.hit_z == '0)
		else $error("miss word with nonzero point");

	// the divider stalls only behind a held output word
	assert property (@(posedge clk) disable iff (!arst_n)
		!up_ready |-> v_out_q && !dn_ready)
		else $error("divider stalled without back pressure");

endmodule

>>> hw/rtl/segment_plane_patch_intersection_3d.sv
// ----------------------------------------------------------------------------
// segment_plane_patch_intersection_3d: segment versus plane patch, pipelined
// one query per cycle in when not stalled; one result per query out, in order
// ----------------------------------------------------------------------------
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  query    | query_valid, query_ready, query      | in
//  result   | result_valid, result_ready, result   | out
//
//  a query word enters every cycle unless a held result backs up the pipe;
//  it passes 4 geometry, 3 test/product, CoordBits + 1 divider and 1 output
//  stage on its way out; the divider retires one quotient bit per stage
//  reset clears only the valid bits; payload registers hold what they hold
//  a held result stalls only stages that are full; bubbles still fill up
//
module segment_plane_patch_intersection_3d
	import sppi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    query_valid,
	output logic    query_ready,
	input  query_t  query,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// geometry front end to bound tests
	logic  geo_valid, geo_ready;
	geom_t geo_word;

	// bound tests to divider
	logic  cnd_valid, cnd_ready;
	div_t  cnd_word;

	// differences, cross products, denominator and numerators
	sppi_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (query_valid),
		.up_ready (query_ready),
		.up_word  (query),
		.dn_valid (geo_valid),
		.dn_ready (geo_ready),
		.dn_word  (geo_word)
	);

	// sign fix, t/u/v bounds and the per-axis dividend
	sppi_cond u_cond (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (geo_valid),
		.up_ready (geo_ready),
		.up_word  (geo_word),
		.dn_valid (cnd_valid),
		.dn_ready (cnd_ready),
		.dn_word  (cnd_word)
	);

	// quotient, rounding, saturation and output register
	sppi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cnd_valid),
		.up_ready (cnd_ready),
		.up_word  (cnd_word),
		.dn_valid (result_valid),
		.dn_ready (result_ready),
		.dn_word  (result)
	);

endmodule
